// ----- rtl/core/segcirc_pkg.sv -----
// ----------------------------------------------------------------------------
// segcirc_pkg
// Shared constants of the segment / circle intersection pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package segcirc_pkg;

    // default coordinate width, signed fixed point
    localparam int COORD_WIDTH_DEF = 16;
    // fraction bits of the unit direction vector
    localparam int DIR_FRAC = 30;

endpackage : segcirc_pkg

`default_nettype wire

// ----- rtl/core/segment_circle_intersect.sv -----
// ----------------------------------------------------------------------------
// segment_circle_intersect
// Pipelined test of a line segment against a circle, two hit points and normals.
// Throughput: one item per cycle while the skid register is empty; depth is
// set by the two bit-serial square roots and the direction and normal
// dividers, one quotient bit per stage.
// Reset clears the stage valid bits and the output and skid valid flags only.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_circle_intersect #(
    parameter int COORD_WIDTH = segcirc_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic signed [COORD_WIDTH-1:0] i_start_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_start_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_end_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_end_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_center_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_center_y,
    input  wire logic        [COORD_WIDTH-2:0] i_circle_radius,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic                               o_hit,
    output logic signed [COORD_WIDTH-1:0]      o_near_x,
    output logic signed [COORD_WIDTH-1:0]      o_near_y,
    output logic signed [COORD_WIDTH-1:0]      o_near_normal_x,
    output logic signed [COORD_WIDTH-1:0]      o_near_normal_y,
    output logic signed [COORD_WIDTH-1:0]      o_far_x,
    output logic signed [COORD_WIDTH-1:0]      o_far_y,
    output logic signed [COORD_WIDTH-1:0]      o_far_normal_x,
    output logic signed [COORD_WIDTH-1:0]      o_far_normal_y
);
    import segcirc_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int RW  = W - 1;           // radius width
    localparam int DW  = W + 1;           // coordinate differences
    localparam int LW  = W + 1;           // segment length
    localparam int SW  = 2 * LW;          // square root operand
    localparam int FB  = DIR_FRAC;
    localparam int QB  = FB + 1;          // direction quotient bits
    localparam int UW  = FB + 2;          // signed direction
    localparam int PRW = DW + UW;         // dot product terms
    localparam int TW  = W + 3;           // t0
    localparam int MW  = UW + TW + 1;     // direction times t
    localparam int PW  = W + 4;           // unsaturated points

    // stage indexes: stage i computes the content of stage i+1
    localparam int ST_SQRT0 = 2;
    localparam int ST_LEN   = ST_SQRT0 + LW;
    localparam int ST_UDIV0 = ST_LEN + 1;
    localparam int ST_UDIR  = ST_UDIV0 + QB;
    localparam int ST_DOTM  = ST_UDIR + 1;
    localparam int ST_DOTS  = ST_UDIR + 2;
    localparam int ST_T0    = ST_UDIR + 3;
    localparam int ST_T0SQ  = ST_UDIR + 4;
    localparam int ST_D2    = ST_UDIR + 5;
    localparam int ST_RT0   = ST_UDIR + 6;
    localparam int ST_TAN   = ST_RT0 + RW;
    localparam int ST_PM    = ST_TAN + 1;
    localparam int ST_PT    = ST_TAN + 2;
    localparam int ST_NINIT = ST_TAN + 3;
    localparam int ST_NDIV0 = ST_TAN + 4;
    localparam int ST_LAST  = ST_NDIV0 + W;
    localparam int NS       = ST_LAST + 1;

    localparam logic [PRW:0]  HALF_D = (PRW + 1)'(1) << (FB - 1);
    localparam logic [MW-1:0] HALF_M = MW'(1) << (FB - 1);
    localparam logic [W-1:0]  Q_MAX  = {1'b0, {(W - 1){1'b1}}};
    localparam logic [W-1:0]  Q_MIN  = {1'b1, {(W - 1){1'b0}}};

    typedef struct packed {
        logic signed [W-1:0]   sx;
        logic signed [W-1:0]   sy;
        logic signed [W-1:0]   cxa;
        logic signed [W-1:0]   cya;
        logic [RW-1:0]         r;
        logic signed [DW-1:0]  dx;
        logic signed [DW-1:0]  dy;
        logic signed [DW-1:0]  cx;
        logic signed [DW-1:0]  cy;
        logic [SW-1:0]         sqa;
        logic [SW-1:0]         sqb;
        logic [SW-1:0]         sqc;
        logic [SW-1:0]         sqd;
        logic [SW-1:0]         cc;
        logic [SW-1:0]         s;
        logic [LW:0]           rem;
        logic [LW-1:0]         root;
        logic [LW-1:0]         len;
        logic [LW-1:0]         drx;
        logic [LW-1:0]         dry;
        logic [QB-1:0]         qx;
        logic [QB-1:0]         qy;
        logic                  negx;
        logic                  negy;
        logic signed [UW-1:0]  ux;
        logic signed [UW-1:0]  uy;
        logic signed [PRW-1:0] pmx;
        logic signed [PRW-1:0] pmy;
        logic signed [PRW:0]   dot;
        logic signed [TW-1:0]  t0;
        logic signed [2*TW-1:0] t0sq;
        logic [2*RW-1:0]       r2;
        logic signed [TW:0]    ta;
        logic signed [TW:0]    tb;
        logic [3:0][MW-1:0]    m;
        logic [3:0][PW-1:0]    p;
        logic [3:0][RW-1:0]    nrem;
        logic [3:0][W-1:0]     nq;
        logic [3:0]            nneg;
        logic [3:0]            novf;
        logic                  miss;
    } t_item;

    typedef struct packed {
        logic                hit;
        logic [3:0][W-1:0]   pt;
        logic [3:0][W-1:0]   nm;
    } t_res;

    function automatic t_item f_stage(input int idx, input t_item it);
        t_item                  o;
        logic [LW+1:0]          sr2;
        logic [LW+1:0]          strial;
        logic [DW-1:0]          magx;
        logic [DW-1:0]          magy;
        logic [DW+FB-1:0]       numx;
        logic [DW+FB-1:0]       numy;
        logic [LW:0]            dr2x;
        logic [LW:0]            dr2y;
        logic [PRW:0]           dmag;
        logic [PRW:0]           drnd;
        logic signed [2*TW:0]   d2;
        logic [2*RW-1:0]        val;
        logic signed [TW-1:0]   t1s;
        logic signed [TW:0]     lens;
        logic signed [MW-1:0]   mp;
        logic [MW-1:0]          mmag;
        logic [MW-1:0]          mrnd;
        logic signed [PW-1:0]   rs;
        logic signed [PW-1:0]   base;
        logic signed [PW-1:0]   cen;
        logic signed [PW:0]     diff;
        logic [PW:0]            nmag;
        logic [PW+W-2:0]        nnum;
        logic [PW-2:0]          nhi;
        logic [W-1:0]           nr2;
        logic                   ge;
        begin
            o = it;
            if (idx == 0) begin
                o.sqa = it.dx * it.dx;
                o.sqb = it.dy * it.dy;
                o.sqc = it.cx * it.cx;
                o.sqd = it.cy * it.cy;
                o.r2  = it.r * it.r;
            end else if (idx == 1) begin
                o.s    = it.sqa + it.sqb;
                o.cc   = it.sqc + it.sqd;
                o.rem  = '0;
                o.root = '0;
            end else if ((idx >= ST_SQRT0 && idx < ST_LEN) ||
                         (idx >= ST_RT0 && idx < ST_TAN)) begin
                // one result bit of the digit-by-digit square root
                sr2    = {it.rem[LW-1:0], it.s[SW-1 -: 2]};
                strial = {it.root, 2'b01};
                if (sr2 >= strial) begin
                    o.rem  = (LW + 1)'(sr2 - strial);
                    o.root = {it.root[LW-2:0], 1'b1};
                end else begin
                    o.rem  = sr2[LW:0];
                    o.root = {it.root[LW-2:0], 1'b0};
                end
                o.s = it.s << 2;
            end else if (idx == ST_LEN) begin
                o.len  = it.root;
                o.miss = (it.root == '0) || (it.r == '0);
                magx   = it.dx[DW-1] ? DW'(-it.dx) : DW'(it.dx);
                magy   = it.dy[DW-1] ? DW'(-it.dy) : DW'(it.dy);
                numx   = {magx, {FB{1'b0}}} + (DW + FB)'(it.root >> 1);
                numy   = {magy, {FB{1'b0}}} + (DW + FB)'(it.root >> 1);
                o.drx  = LW'(numx[DW+FB-1:QB]);
                o.dry  = LW'(numy[DW+FB-1:QB]);
                o.qx   = numx[QB-1:0];
                o.qy   = numy[QB-1:0];
                o.negx = it.dx[DW-1];
                o.negy = it.dy[DW-1];
            end else if (idx >= ST_UDIV0 && idx < ST_UDIR) begin
                // dividend bits leave the top of q as quotient bits enter
                dr2x = {it.drx, it.qx[QB-1]};
                ge   = dr2x >= {1'b0, it.len};
                o.drx = ge ? LW'(dr2x - {1'b0, it.len}) : dr2x[LW-1:0];
                o.qx  = {it.qx[QB-2:0], ge};
                dr2y = {it.dry, it.qy[QB-1]};
                ge   = dr2y >= {1'b0, it.len};
                o.dry = ge ? LW'(dr2y - {1'b0, it.len}) : dr2y[LW-1:0];
                o.qy  = {it.qy[QB-2:0], ge};
            end else if (idx == ST_UDIR) begin
                o.ux = it.negx ? -UW'(it.qx) : UW'(it.qx);
                o.uy = it.negy ? -UW'(it.qy) : UW'(it.qy);
            end else if (idx == ST_DOTM) begin
                o.pmx = it.cx * it.ux;
                o.pmy = it.cy * it.uy;
            end else if (idx == ST_DOTS) begin
                o.dot = (PRW + 1)'(it.pmx) + (PRW + 1)'(it.pmy);
            end else if (idx == ST_T0) begin
                dmag = it.dot[PRW] ? (PRW + 1)'(-it.dot) : (PRW + 1)'(it.dot);
                drnd = (dmag + HALF_D) >> FB;
                o.t0 = TW'(drnd);
                if (it.dot[PRW]) begin
                    o.t0 = -o.t0;
                end
            end else if (idx == ST_T0SQ) begin
                o.t0sq = it.t0 * it.t0;
            end else if (idx == ST_D2) begin
                d2 = $signed((2 * TW + 1)'(it.cc)) - (2 * TW + 1)'(it.t0sq);
                if (d2 < 0) begin
                    d2 = '0;
                end
                if (d2 > $signed((2 * TW + 1)'(it.r2))) begin
                    o.miss = 1'b1;
                end
                val    = it.r2 - d2[2*RW-1:0];
                o.s    = {val, {(SW - 2 * RW){1'b0}}};
                o.rem  = '0;
                o.root = '0;
            end else if (idx == ST_TAN) begin
                t1s = TW'(it.root[RW-1:0]);
                // tangent rule: flip the half chord when t0 is not beyond it
                if (it.t0 < t1s + 1) begin
                    t1s = -t1s;
                end
                o.ta = (TW + 1)'(it.t0) - (TW + 1)'(t1s);
                o.tb = (TW + 1)'(it.t0) + (TW + 1)'(t1s);
                lens = $signed((TW + 1)'(it.len));
                if (o.ta > lens || o.tb < lens) begin
                    o.miss = 1'b1;
                end
            end else if (idx == ST_PM) begin
                mp = it.ux * it.ta;
                o.m[0] = mp;
                mp = it.uy * it.ta;
                o.m[1] = mp;
                mp = it.ux * it.tb;
                o.m[2] = mp;
                mp = it.uy * it.tb;
                o.m[3] = mp;
            end else if (idx == ST_PT) begin
                for (int k = 0; k < 4; k++) begin
                    mmag = it.m[k][MW-1] ? MW'(-$signed(it.m[k])) : it.m[k];
                    mrnd = (mmag + HALF_M) >> FB;
                    rs   = PW'(mrnd);
                    if (it.m[k][MW-1]) begin
                        rs = -rs;
                    end
                    base   = (k % 2 == 0) ? PW'(it.sx) : PW'(it.sy);
                    o.p[k] = base + rs;
                end
            end else if (idx == ST_NINIT) begin
                for (int k = 0; k < 4; k++) begin
                    cen  = (k % 2 == 0) ? PW'(it.cxa) : PW'(it.cya);
                    diff = (PW + 1)'($signed(it.p[k])) - (PW + 1)'(cen);
                    nmag = diff[PW] ? (PW + 1)'(-diff) : (PW + 1)'(diff);
                    nnum = {nmag, {(W - 2){1'b0}}} + (PW + W - 1)'(it.r >> 1);
                    nhi  = nnum[PW+W-2:W];
                    o.novf[k] = nhi >= (PW - 1)'(it.r);
                    o.nrem[k] = nhi[RW-1:0];
                    o.nq[k]   = nnum[W-1:0];
                    o.nneg[k] = diff[PW];
                end
            end else if (idx >= ST_NDIV0 && idx < ST_LAST) begin
                for (int k = 0; k < 4; k++) begin
                    nr2 = {it.nrem[k], it.nq[k][W-1]};
                    ge  = nr2 >= W'(it.r);
                    o.nrem[k] = ge ? RW'(nr2 - W'(it.r)) : nr2[RW-1:0];
                    o.nq[k]   = {it.nq[k][W-2:0], ge};
                end
            end
            return o;
        end
    endfunction

    function automatic logic [W-1:0] f_sat_pt(input logic signed [PW-1:0] v);
        begin
            if (v > $signed(PW'(Q_MAX))) begin
                return Q_MAX;
            end else if (v < -$signed(PW'(Q_MIN))) begin
                return Q_MIN;
            end
            return v[W-1:0];
        end
    endfunction

    function automatic logic [W-1:0] f_sat_nm(input logic [W-1:0] q, input logic neg,
                                               input logic ovf);
        begin
            if (neg) begin
                if (ovf || q > Q_MIN) begin
                    return Q_MIN;
                end
                return W'(-q);
            end
            if (ovf || q > Q_MAX) begin
                return Q_MAX;
            end
            return q;
        end
    endfunction

    t_item          r_pipe [NS];
    logic [NS-1:0]  r_vld;
    t_item          n_load;
    t_res           n_res;
    t_res           r_out;
    t_res           r_skid;
    logic           r_out_vld;
    logic           r_skid_vld;
    logic           pipe_en;
    logic           push;
    logic           pop;

    // the whole pipe moves unless the skid register is occupied
    assign pipe_en    = !r_skid_vld;
    assign o_in_ready = pipe_en;

    always_comb begin
        n_load     = '0;
        n_load.sx  = i_start_x;
        n_load.sy  = i_start_y;
        n_load.cxa = i_center_x;
        n_load.cya = i_center_y;
        n_load.r   = i_circle_radius;
        n_load.dx  = DW'(i_end_x) - DW'(i_start_x);
        n_load.dy  = DW'(i_end_y) - DW'(i_start_y);
        n_load.cx  = DW'(i_center_x) - DW'(i_start_x);
        n_load.cy  = DW'(i_center_y) - DW'(i_start_y);
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_pipe[0] <= n_load;
        end
    end

    for (genvar g = 0; g < NS - 1; g++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (pipe_en) begin
                r_pipe[g+1] <= f_stage(g, r_pipe[g]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (pipe_en) begin
            r_vld <= {r_vld[NS-2:0], i_in_valid};
        end
    end

    always_comb begin
        n_res = '0;
        if (!r_pipe[ST_LAST].miss) begin
            n_res.hit = 1'b1;
            for (int k = 0; k < 4; k++) begin
                n_res.pt[k] = f_sat_pt($signed(r_pipe[ST_LAST].p[k]));
                n_res.nm[k] = f_sat_nm(r_pipe[ST_LAST].nq[k], r_pipe[ST_LAST].nneg[k],
                                       r_pipe[ST_LAST].novf[k]);
            end
        end
    end

    assign push = pipe_en && r_vld[ST_LAST];
    assign pop  = r_out_vld && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (pop) begin
                r_skid_vld <= 1'b0;
            end
        end else if (push) begin
            if (r_out_vld && !pop) begin
                r_skid_vld <= 1'b1;
            end else begin
                r_out_vld <= 1'b1;
            end
        end else if (pop) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (push) begin
            if (r_out_vld && !pop) begin
                r_skid <= n_res;
            end else begin
                r_out <= n_res;
            end
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_hit           = r_out.hit;
    assign o_near_x        = r_out.pt[0];
    assign o_near_y        = r_out.pt[1];
    assign o_far_x         = r_out.pt[2];
    assign o_far_y         = r_out.pt[3];
    assign o_near_normal_x = r_out.nm[0];
    assign o_near_normal_y = r_out.nm[1];
    assign o_far_normal_x  = r_out.nm[2];
    assign o_far_normal_y  = r_out.nm[3];

`ifndef SYNTHESIS
    // the skid register only fills behind a waiting output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid register holds a result with no output pending");

    // a miss carries all-zero coordinates and normals
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_hit) |-> (o_near_x == '0 && o_near_y == '0 &&
            o_far_x == '0 && o_far_y == '0 && o_near_normal_x == '0 &&
            o_near_normal_y == '0 && o_far_normal_x == '0 && o_far_normal_y == '0))
        else $error("miss result with nonzero fields");

    // reset empties the output side
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_in_ready))
        else $error("output not empty after reset");
`endif

endmodule : segment_circle_intersect

`default_nettype wire

// ----- tb/segment_circle_intersect_checker.sv -----
// ----------------------------------------------------------------------------
// segment_circle_intersect_checker
// Watches both channels of the segment / circle pipeline, predicts each result
// from the accepted inputs and compares it field by field with the output.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_circle_intersect_checker #(
    parameter int CW = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_in_ready,
    input  wire logic signed [CW-1:0] i_start_x,
    input  wire logic signed [CW-1:0] i_start_y,
    input  wire logic signed [CW-1:0] i_end_x,
    input  wire logic signed [CW-1:0] i_end_y,
    input  wire logic signed [CW-1:0] i_center_x,
    input  wire logic signed [CW-1:0] i_center_y,
    input  wire logic        [CW-2:0] i_circle_radius,
    input  wire logic                 i_out_valid,
    input  wire logic                 i_out_ready,
    input  wire logic                 i_hit,
    input  wire logic signed [CW-1:0] i_near_x,
    input  wire logic signed [CW-1:0] i_near_y,
    input  wire logic signed [CW-1:0] i_near_normal_x,
    input  wire logic signed [CW-1:0] i_near_normal_y,
    input  wire logic signed [CW-1:0] i_far_x,
    input  wire logic signed [CW-1:0] i_far_y,
    input  wire logic signed [CW-1:0] i_far_normal_x,
    input  wire logic signed [CW-1:0] i_far_normal_y,
    output int                        o_fail_count,
    output int                        o_pending
);

    import segcirc_pkg::*;

    typedef struct packed {
        logic                 hit;
        logic signed [CW-1:0] nx, ny, nnx, nny, fx, fy, fnx, fny;
    } t_crossing;

    t_crossing crossing_q[$];

    function automatic longint int_sqrt(longint v);
        longint res, bitv;
        res  = 0;
        bitv = 64'sd1 <<< 62;
        while (bitv > v) bitv = bitv >>> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >>> 1) + bitv;
            end else begin
                res = res >>> 1;
            end
            bitv = bitv >>> 2;
        end
        return res;
    endfunction

    function automatic longint round_div(longint num, longint den);
        longint m, q;
        m = (num < 0) ? -num : num;
        q = (m + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint round_shift(longint v, int s);
        longint m, q;
        m = (v < 0) ? -v : v;
        q = (m + (64'sd1 <<< (s - 1))) >>> s;
        return (v < 0) ? -q : q;
    endfunction

    function automatic logic signed [CW-1:0] clip(longint v);
        longint hi, lo;
        hi = (64'sd1 <<< (CW - 1)) - 1;
        lo = -(64'sd1 <<< (CW - 1));
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return v[CW-1:0];
    endfunction

    function automatic t_crossing predict_crossing(longint sx, longint sy, longint ex,
                                                   longint ey, longint kx, longint ky,
                                                   longint r);
        t_crossing res;
        longint dx, dy, cx, cy, len, ux, uy, t0, d2, r2, t1, ta, tb;
        longint p1x, p1y, p2x, p2y, nscale;
        res    = '0;
        dx     = ex - sx;
        dy     = ey - sy;
        cx     = kx - sx;
        cy     = ky - sy;
        nscale = 64'sd1 <<< (CW - 2);
        len    = int_sqrt(dx * dx + dy * dy);
        if (len == 0 || r == 0) return res;
        ux = round_div(dx * (64'sd1 <<< DIR_FRAC), len);
        uy = round_div(dy * (64'sd1 <<< DIR_FRAC), len);
        t0 = round_shift(cx * ux + cy * uy, DIR_FRAC);
        d2 = cx * cx + cy * cy - t0 * t0;
        if (d2 < 0) d2 = 0;
        r2 = r * r;
        if (d2 > r2) return res;
        t1 = int_sqrt(r2 - d2);
        // t0 not beyond the half chord, e.g. centre behind the start: flip the half chord
        if (t0 < t1 + 1) t1 = -t1;
        ta = t0 - t1;
        tb = t0 + t1;
        if (ta > len || tb < len) return res;
        p1x = sx + round_shift(ux * ta, DIR_FRAC);
        p1y = sy + round_shift(uy * ta, DIR_FRAC);
        p2x = sx + round_shift(ux * tb, DIR_FRAC);
        p2y = sy + round_shift(uy * tb, DIR_FRAC);
        res.hit = 1'b1;
        res.nx  = clip(p1x);
        res.ny  = clip(p1y);
        res.nnx = clip(round_div((p1x - kx) * nscale, r));
        res.nny = clip(round_div((p1y - ky) * nscale, r));
        res.fx  = clip(p2x);
        res.fy  = clip(p2y);
        res.fnx = clip(round_div((p2x - kx) * nscale, r));
        res.fny = clip(round_div((p2y - ky) * nscale, r));
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        o_fail_count++;
    endtask

    assign o_pending = crossing_q.size();

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        t_crossing want;
        if (i_rst_n && i_in_valid && i_in_ready)
            crossing_q = {crossing_q, predict_crossing(i_start_x, i_start_y, i_end_x,
                                                       i_end_y, i_center_x, i_center_y,
                                                       longint'(i_circle_radius))};
        if (i_rst_n && i_out_valid && i_out_ready) begin
            if (crossing_q.size() == 0) begin
                report_mismatch("unexpected transfer", 1, 0);
            end else begin
                want = crossing_q.pop_front();
                if (i_hit !== want.hit)           report_mismatch("hit", i_hit, want.hit);
                if (i_near_x !== want.nx)         report_mismatch("near_x", i_near_x, want.nx);
                if (i_near_y !== want.ny)         report_mismatch("near_y", i_near_y, want.ny);
                if (i_near_normal_x !== want.nnx)
                    report_mismatch("near_normal_x", i_near_normal_x, want.nnx);
                if (i_near_normal_y !== want.nny)
                    report_mismatch("near_normal_y", i_near_normal_y, want.nny);
                if (i_far_x !== want.fx)          report_mismatch("far_x", i_far_x, want.fx);
                if (i_far_y !== want.fy)          report_mismatch("far_y", i_far_y, want.fy);
                if (i_far_normal_x !== want.fnx)
                    report_mismatch("far_normal_x", i_far_normal_x, want.fnx);
                if (i_far_normal_y !== want.fny)
                    report_mismatch("far_normal_y", i_far_normal_y, want.fny);
            end
        end
    end

endmodule : segment_circle_intersect_checker

`default_nettype wire

// ----- tb/segment_circle_intersect_test.sv -----
// ----------------------------------------------------------------------------
// segment_circle_intersect_test
// Drives directed and random segment / circle pairs with random idle cycles
// on both sides; the checker predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_circle_intersect_test;

    localparam int CW      = 16;
    localparam int LATENCY = 3 * CW + 45;
    localparam int N_RAND  = 800;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic signed [CW-1:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
    logic signed [CW-1:0] center_x = '0, center_y = '0;
    logic        [CW-2:0] circle_radius = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              hit;
    logic signed [CW-1:0] near_x, near_y, near_normal_x, near_normal_y;
    logic signed [CW-1:0] far_x, far_y, far_normal_x, far_normal_y;
    int                fail_count;
    int                pending;
    logic              calm = 1'b0;

    always #4 clk = ~clk;

    segment_circle_intersect #(.COORD_WIDTH(CW)) dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_start_x(start_x), .i_start_y(start_y), .i_end_x(end_x), .i_end_y(end_y),
        .i_center_x(center_x), .i_center_y(center_y), .i_circle_radius(circle_radius),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_hit(hit),
        .o_near_x(near_x), .o_near_y(near_y),
        .o_near_normal_x(near_normal_x), .o_near_normal_y(near_normal_y),
        .o_far_x(far_x), .o_far_y(far_y),
        .o_far_normal_x(far_normal_x), .o_far_normal_y(far_normal_y)
    );

    segment_circle_intersect_checker #(.CW(CW)) u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_start_x(start_x), .i_start_y(start_y), .i_end_x(end_x), .i_end_y(end_y),
        .i_center_x(center_x), .i_center_y(center_y), .i_circle_radius(circle_radius),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_hit(hit),
        .i_near_x(near_x), .i_near_y(near_y),
        .i_near_normal_x(near_normal_x), .i_near_normal_y(near_normal_y),
        .i_far_x(far_x), .i_far_y(far_y),
        .i_far_normal_x(far_normal_x), .i_far_normal_y(far_normal_y),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver drops ready at random, never in the calm stretch
    always @(posedge clk) begin
        out_ready <= calm || ($urandom_range(99) >= 11);
    end

    // one transfer; optional idle cycles first
    task automatic send_pair(int sx, int sy, int ex, int ey, int kx, int ky, int r);
        while (!calm && $urandom_range(99) < 11) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        start_x       <= sx[CW-1:0];
        start_y       <= sy[CW-1:0];
        end_x         <= ex[CW-1:0];
        end_y         <= ey[CW-1:0];
        center_x      <= kx[CW-1:0];
        center_y      <= ky[CW-1:0];
        circle_radius <= r[CW-2:0];
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    function automatic int rnd_coord();
        return int'($urandom_range(65535)) - 32768;
    endfunction

    function automatic int rnd_small();
        return int'($urandom_range(16383)) - 8192;
    endfunction

    initial begin
        int sx, sy, ex, ey, kx, ky, r, ang, waited;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: crossing, extremes, degenerate, zero radius, tangent, centre behind
        send_pair(-8192, 0, 8192, 0, 0, 0, 4096);
        send_pair(-32768, -32768, 32767, 32767, 0, 0, 32767);
        send_pair(32767, -32768, -32768, 32767, 32767, 32767, 32767);
        send_pair(-32768, 32767, 32767, -32768, -32768, -32768, 16384);
        send_pair(100, 100, 100, 100, 100, 100, 4096);
        send_pair(-4096, 0, 4096, 0, 0, 0, 0);
        send_pair(-8192, 4096, 8192, 4096, 0, 0, 4096);
        send_pair(-8192, 4097, 8192, 4097, 0, 0, 4096);
        send_pair(0, 0, 8192, 0, 0, 0, 4096);
        send_pair(0, 0, 8192, 0, -2048, 0, 4096);
        send_pair(0, 0, 8192, 0, 12000, 0, 4096);
        send_pair(0, 0, 0, 8192, 0, 4096, 1);
        send_pair(0, 0, 1, 0, 0, 0, 32767);
        send_pair(-32768, 0, 32767, 0, 0, 32767, 32767);
        send_pair(0, -32768, 0, 32767, -32768, 0, 32767);
        send_pair(-1, -1, 0, 0, 0, 0, 1);
        send_pair(0, 0, 20000, 0, 10000, 100, 1);

        for (int i = 0; i < N_RAND; i++) begin
            calm = (i >= 300 && i < 420);
            case ($urandom_range(3))
                0: begin
                    sx = rnd_coord(); sy = rnd_coord(); ex = rnd_coord(); ey = rnd_coord();
                    kx = rnd_coord(); ky = rnd_coord(); r = $urandom_range(32767);
                end
                default: begin
                    // mostly pairs that cross, with small coordinates
                    sx = rnd_small(); sy = rnd_small();
                    ex = rnd_small(); ey = rnd_small();
                    ang = $urandom_range(1024);
                    kx = sx + ((ex - sx) * ang) / 1024 + int'($urandom_range(2000)) - 1000;
                    ky = sy + ((ey - sy) * ang) / 1024 + int'($urandom_range(2000)) - 1000;
                    r  = $urandom_range(8000, 1);
                end
            endcase
            send_pair(sx, sy, ex, ey, kx, ky, r);
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        waited = 0;
        while (pending != 0 && waited < 100000) begin
            @(posedge clk);
            waited++;
        end
        repeat (LATENCY + 10) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule : segment_circle_intersect_test

`default_nettype wire

// ----- sim.f -----
rtl/core/segcirc_pkg.sv
rtl/core/segment_circle_intersect.sv
tb/segment_circle_intersect_checker.sv
tb/segment_circle_intersect_test.sv
